[sv/triangle_box_overlap_test_macros.svh]
// Assertion macros for the triangle/box overlap top level.
`ifndef TRIANGLE_BOX_OVERLAP_TEST_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define TBO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define TBO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tbo_pkg.sv]
// Shared constants for the triangle/box overlap pipeline.
package tbo_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  // register stages from request to result strobe
  localparam int unsigned PIPE_DEPTH = 6;

endpackage

[sv/tbo_face.sv]
// Box face axes: triangle bounding box against the box, one register stage.
module tbo_face #(
  parameter int unsigned W = 16
) (
  input  logic                clk,
  input  logic signed [W:0]   p  [3],
  input  logic signed [W:0]   v1 [3],
  input  logic signed [W:0]   v2 [3],
  input  logic        [W-2:0] h  [3],
  output logic                face_sep
);

  logic signed [W:0] lo [3];
  logic signed [W:0] hi [3];
  logic signed [W:0] hs [3];
  logic        [2:0] axis_sep;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k] = p[k];
      hi[k] = p[k];
      if (v1[k] < lo[k]) lo[k] = v1[k];
      if (v1[k] > hi[k]) hi[k] = v1[k];
      if (v2[k] < lo[k]) lo[k] = v2[k];
      if (v2[k] > hi[k]) hi[k] = v2[k];
      hs[k] = $signed({2'b00, h[k]});
      axis_sep[k] = (lo[k] > hs[k]) || (hi[k] < -hs[k]);
    end
  end

  always_ff @(posedge clk) begin
    face_sep <= |axis_sep;
  end

endmodule

[sv/tbo_edge_axes.sv]
// Three cross axes of one triangle edge: multiply, combine, compare.
module tbo_edge_axes #(
  parameter int unsigned W = 16
) (
  input  logic                clk,
  input  logic signed [W:0]   ed [3],
  input  logic signed [W:0]   va [3],
  input  logic signed [W:0]   vb [3],
  input  logic        [W-2:0] h  [3],
  output logic                sep
);

  localparam int unsigned AW = W + 1;
  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned DW = 2 * W + 4;

  logic signed [PW-1:0] ma0 [3];
  logic signed [PW-1:0] ma1 [3];
  logic signed [PW-1:0] mb0 [3];
  logic signed [PW-1:0] mb1 [3];
  logic signed [PW-1:0] r0  [3];
  logic signed [PW-1:0] r1  [3];
  logic signed [DW-1:0] pa  [3];
  logic signed [DW-1:0] pb  [3];
  logic signed [DW-1:0] rad [3];
  logic        [2:0]    axis_sep;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int unsigned I = (k + 1) % 3;
    localparam int unsigned J = (k + 2) % 3;

    logic [W:0]           abs_i;
    logic [W:0]           abs_j;
    logic signed [DW-1:0] nrad;

    // magnitude of the most negative value wraps to 2^W, still correct unsigned
    assign abs_i = ed[I][W] ? AW'(-ed[I]) : AW'(ed[I]);
    assign abs_j = ed[J][W] ? AW'(-ed[J]) : AW'(ed[J]);
    assign nrad  = -rad[k];

    always_ff @(posedge clk) begin
      ma0[k] <= PW'(ed[J]) * PW'(va[I]);
      ma1[k] <= PW'(ed[I]) * PW'(va[J]);
      mb0[k] <= PW'(ed[J]) * PW'(vb[I]);
      mb1[k] <= PW'(ed[I]) * PW'(vb[J]);
      r0[k]  <= PW'($signed({1'b0, abs_j})) * PW'($signed({1'b0, h[I]}));
      r1[k]  <= PW'($signed({1'b0, abs_i})) * PW'($signed({1'b0, h[J]}));

      pa[k]  <= DW'(ma0[k]) - DW'(ma1[k]);
      pb[k]  <= DW'(mb0[k]) - DW'(mb1[k]);
      rad[k] <= DW'(r0[k]) + DW'(r1[k]);

      // touching the radius is not separation
      axis_sep[k] <= ((pa[k] > rad[k]) && (pb[k] > rad[k])) ||
                     ((pa[k] < nrad) && (pb[k] < nrad));
    end
  end

  assign sep = |axis_sep;

endmodule

[sv/tbo_plane.sv]
// Triangle plane against the box: normal, near/far corner offsets, dot sums.
module tbo_plane #(
  parameter int unsigned W = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] p [3],
  input  logic signed [W-1:0] u [3],
  input  logic signed [W-1:0] v [3],
  input  logic        [W-2:0] h [3],
  output logic                plane_ok
);

  localparam int unsigned TW = 2 * W;
  localparam int unsigned NW = 2 * W + 1;
  localparam int unsigned CW = W + 1;
  localparam int unsigned QW = 3 * W + 2;
  localparam int unsigned SW = 3 * W + 4;

  logic signed [TW-1:0] t0     [3];
  logic signed [TW-1:0] t1     [3];
  logic signed [W-1:0]  p_b    [3];
  logic        [W-2:0]  h_b    [3];
  logic signed [NW-1:0] n_c    [3];
  logic signed [CW-1:0] wmin_c [3];
  logic signed [CW-1:0] wmax_c [3];
  logic signed [QW-1:0] qmin_d [3];
  logic signed [QW-1:0] qmax_d [3];
  logic signed [SW-1:0] smin;
  logic signed [SW-1:0] smax;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int unsigned I = (k + 1) % 3;
    localparam int unsigned J = (k + 2) % 3;

    logic signed [CW-1:0] hs;
    logic signed [CW-1:0] pc;
    logic                 pos;

    assign hs  = $signed({2'b00, h_b[k]});
    assign pc  = CW'(p_b[k]);
    assign pos = t0[k] > t1[k];

    always_ff @(posedge clk) begin
      t0[k]  <= TW'(v[I]) * TW'(u[J]);
      t1[k]  <= TW'(v[J]) * TW'(u[I]);
      p_b[k] <= p[k];
      h_b[k] <= h[k];

      // zero normal component takes +h for the near corner
      n_c[k]    <= NW'(t0[k]) - NW'(t1[k]);
      wmin_c[k] <= pos ? (-hs - pc) : (hs - pc);
      wmax_c[k] <= pos ? (hs - pc) : (-hs - pc);

      qmin_d[k] <= QW'(n_c[k]) * QW'(wmin_c[k]);
      qmax_d[k] <= QW'(n_c[k]) * QW'(wmax_c[k]);
    end
  end

  assign smin = SW'(qmin_d[0]) + SW'(qmin_d[1]) + SW'(qmin_d[2]);
  assign smax = SW'(qmax_d[0]) + SW'(qmax_d[1]) + SW'(qmax_d[2]);

  always_ff @(posedge clk) begin
    plane_ok <= (smin <= 0) && (smax >= 0);
  end

endmodule

[sv/triangle_box_overlap_test.sv]
// Top level: triangle versus axis-aligned box overlap, fully pipelined.
//
//   channel   handshake        payload
//   request   start / busy     base_*, edge_u_*, edge_v_*, half_size_*
//   result    done (strobe)    overlaps
//
// One request per cycle; busy stays low, the pipeline never stops.
// Result strobe comes from the last of the PIPE_DEPTH register stages.
// Six register stages: input and vertex adds, products, differences and sums,
// axis compares and plane products, plane sums, result.
// rst clears the valid bits only; requests in flight at reset are dropped.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`include "triangle_box_overlap_test_macros.svh"

module triangle_box_overlap_test
  import tbo_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] base_x,
  input  logic signed [COORD_WIDTH-1:0] base_y,
  input  logic signed [COORD_WIDTH-1:0] base_z,
  input  logic signed [COORD_WIDTH-1:0] edge_u_x,
  input  logic signed [COORD_WIDTH-1:0] edge_u_y,
  input  logic signed [COORD_WIDTH-1:0] edge_u_z,
  input  logic signed [COORD_WIDTH-1:0] edge_v_x,
  input  logic signed [COORD_WIDTH-1:0] edge_v_y,
  input  logic signed [COORD_WIDTH-1:0] edge_v_z,
  input  logic        [COORD_WIDTH-2:0] half_size_x,
  input  logic        [COORD_WIDTH-2:0] half_size_y,
  input  logic        [COORD_WIDTH-2:0] half_size_z,
  output logic                          done,
  output logic                          overlaps
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned XW = W + 1;

  logic signed [W-1:0] p_in [3];
  logic signed [W-1:0] u_in [3];
  logic signed [W-1:0] v_in [3];
  logic        [W-2:0] h_in [3];

  logic signed [W-1:0] p_a  [3];
  logic signed [W-1:0] u_a  [3];
  logic signed [W-1:0] v_a  [3];
  logic        [W-2:0] h_a  [3];
  logic signed [W:0]   v1_a [3];
  logic signed [W:0]   v2_a [3];
  logic signed [W:0]   e_a  [3];
  logic signed [W:0]   p_x  [3];
  logic signed [W:0]   u_x  [3];
  logic signed [W:0]   v_x  [3];

  logic [PIPE_DEPTH-1:0] vld;
  logic                  accept;
  logic                  sep_u;
  logic                  sep_e;
  logic                  sep_v;
  logic                  edge_sep_e;
  logic                  face_sep_b;
  logic                  face_c;
  logic                  face_d;
  logic                  face_e;
  logic                  plane_ok_e;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign p_in[0] = base_x;
  assign p_in[1] = base_y;
  assign p_in[2] = base_z;
  assign u_in[0] = edge_u_x;
  assign u_in[1] = edge_u_y;
  assign u_in[2] = edge_u_z;
  assign v_in[0] = edge_v_x;
  assign v_in[1] = edge_v_y;
  assign v_in[2] = edge_v_z;
  assign h_in[0] = half_size_x;
  assign h_in[1] = half_size_y;
  assign h_in[2] = half_size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  // stage A: capture the inputs and form the vertices p+u, p+v and the edge v-u
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p_a[k]  <= p_in[k];
      u_a[k]  <= u_in[k];
      v_a[k]  <= v_in[k];
      h_a[k]  <= h_in[k];
      v1_a[k] <= XW'(p_in[k]) + XW'(u_in[k]);
      v2_a[k] <= XW'(p_in[k]) + XW'(v_in[k]);
      e_a[k]  <= XW'(v_in[k]) - XW'(u_in[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_x[k] = XW'(p_a[k]);
      u_x[k] = XW'(u_a[k]);
      v_x[k] = XW'(v_a[k]);
    end
  end

  tbo_edge_axes #(.W(W)) u_edge_u (
    .clk (clk),
    .ed  (u_x),
    .va  (v2_a),
    .vb  (p_x),
    .h   (h_a),
    .sep (sep_u)
  );

  tbo_edge_axes #(.W(W)) u_edge_e (
    .clk (clk),
    .ed  (e_a),
    .va  (p_x),
    .vb  (v1_a),
    .h   (h_a),
    .sep (sep_e)
  );

  tbo_edge_axes #(.W(W)) u_edge_v (
    .clk (clk),
    .ed  (v_x),
    .va  (v1_a),
    .vb  (p_x),
    .h   (h_a),
    .sep (sep_v)
  );

  tbo_face #(.W(W)) u_face (
    .clk      (clk),
    .p        (p_x),
    .v1       (v1_a),
    .v2       (v2_a),
    .h        (h_a),
    .face_sep (face_sep_b)
  );

  tbo_plane #(.W(W)) u_plane (
    .clk      (clk),
    .p        (p_a),
    .u        (u_a),
    .v        (v_a),
    .h        (h_a),
    .plane_ok (plane_ok_e)
  );

  // line the early verdicts up with the plane result
  always_ff @(posedge clk) begin
    face_c     <= face_sep_b;
    face_d     <= face_c;
    face_e     <= face_d;
    edge_sep_e <= sep_u || sep_e || sep_v;
    overlaps   <= !edge_sep_e && !face_e && plane_ok_e;
  end

  assign done = vld[PIPE_DEPTH-1];

  `TBO_ASSERT_IMPL(a_request_to_done, accept, ##PIPE_DEPTH done, "request lost in pipeline")
  `TBO_ASSERT_IMPL(a_done_has_request, done, $past(accept, PIPE_DEPTH), "result without request")
  `TBO_ASSERT_NEXT(a_edge_sep_rejects, vld[PIPE_DEPTH-2] && edge_sep_e, !overlaps, "edge axis ignored")
  `TBO_ASSERT_NEXT(a_face_sep_rejects, vld[PIPE_DEPTH-2] && face_e, !overlaps, "face axis ignored")

endmodule

[tb/tb.sv]
// Self-checking testbench for the triangle versus box overlap pipeline.

typedef logic signed [tbo_pkg::COORD_WIDTH_DEF-1:0] coord_t;
typedef logic        [tbo_pkg::COORD_WIDTH_DEF-2:0] half_t;

typedef struct {
  coord_t base_x, base_y, base_z;
  coord_t edge_u_x, edge_u_y, edge_u_z;
  coord_t edge_v_x, edge_v_y, edge_v_z;
  half_t  half_size_x, half_size_y, half_size_z;
} tri_box_t;

class overlap_scoreboard;
  bit expected_overlap[$];
  int request_id[$];
  int requests_seen;
  int results_checked;
  int overlap_count;
  int mismatches;

  // both projections past the same end of the box radius; touching is not out
  function bit interval_out(longint pa, longint pb, longint rad);
    return (pa > rad && pb > rad) || (pa < -rad && pb < -rad);
  endfunction

  // axes edge x X, Y, Z; a is the vertex off the edge, b one on it
  function bit edge_splits(input longint e[3], input longint a[3], input longint b[3],
                           input longint h[3]);
    longint pa, pb, rad, ei, ej;
    int i, j;
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      pa = e[j] * a[i] - e[i] * a[j];
      pb = e[j] * b[i] - e[i] * b[j];
      ei = (e[i] < 0) ? -e[i] : e[i];
      ej = (e[j] < 0) ? -e[j] : e[j];
      rad = ej * h[i] + ei * h[j];
      if (interval_out(pa, pb, rad)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function bit predict_overlap(tri_box_t r);
    longint p[3], u[3], v[3], h[3], v1[3], v2[3], e[3];
    longint lo, hi, n, cmin, smin, smax;
    int i, j;
    p[0] = r.base_x;   p[1] = r.base_y;   p[2] = r.base_z;
    u[0] = r.edge_u_x; u[1] = r.edge_u_y; u[2] = r.edge_u_z;
    v[0] = r.edge_v_x; v[1] = r.edge_v_y; v[2] = r.edge_v_z;
    h[0] = r.half_size_x; h[1] = r.half_size_y; h[2] = r.half_size_z;
    for (int k = 0; k < 3; k++) begin
      v1[k] = p[k] + u[k];
      v2[k] = p[k] + v[k];
      e[k]  = v[k] - u[k];
    end
    if (edge_splits(u, v2, p, h)) return 1'b0;
    if (edge_splits(e, p, v1, h)) return 1'b0;
    if (edge_splits(v, v1, p, h)) return 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo = p[k];
      hi = p[k];
      if (v1[k] < lo) lo = v1[k];
      if (v1[k] > hi) hi = v1[k];
      if (v2[k] < lo) lo = v2[k];
      if (v2[k] > hi) hi = v2[k];
      if (lo > h[k] || hi < -h[k]) return 1'b0;
    end
    // plane through p with normal v x u, tested at the near and far box corners
    smin = 0;
    smax = 0;
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      n = v[i] * u[j] - v[j] * u[i];
      cmin = (n > 0) ? -h[k] : h[k];
      smin += n * (cmin - p[k]);
      smax += n * (-cmin - p[k]);
    end
    return !(smin > 0) && (smax >= 0);
  endfunction

  function void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", what);
  endfunction

  function void note_request(tri_box_t r);
    expected_overlap.push_back(predict_overlap(r));
    request_id.push_back(requests_seen);
    requests_seen++;
  endfunction

  function void check_result(logic actual);
    bit want;
    int id;
    if (expected_overlap.size() == 0) begin
      report_mismatch($sformatf("result overlaps=%b with no request outstanding", actual));
      return;
    end
    want = expected_overlap.pop_front();
    id = request_id.pop_front();
    results_checked++;
    if (want) overlap_count++;
    if (actual !== want)
      report_mismatch($sformatf("request %0d overlaps expected %b actual %b", id, want, actual));
  endfunction

  function int pending();
    return expected_overlap.size();
  endfunction

  function void check_drained();
    while (expected_overlap.size() != 0) begin
      report_mismatch($sformatf("request %0d never produced a result", request_id[0]));
      void'(expected_overlap.pop_front());
      void'(request_id.pop_front());
    end
  endfunction
endclass

module tb;
  import tbo_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int COORD_MAX = (1 << (CW - 1)) - 1;
  localparam int COORD_MIN = -(1 << (CW - 1));
  localparam int RANDOM_ITEMS = 900;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  coord_t base_x, base_y, base_z;
  coord_t edge_u_x, edge_u_y, edge_u_z;
  coord_t edge_v_x, edge_v_y, edge_v_z;
  half_t  half_size_x, half_size_y, half_size_z;
  logic   done;
  logic   overlaps;

  overlap_scoreboard sb = new();

  triangle_box_overlap_test u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .base_x      (base_x),
    .base_y      (base_y),
    .base_z      (base_z),
    .edge_u_x    (edge_u_x),
    .edge_u_y    (edge_u_y),
    .edge_u_z    (edge_u_z),
    .edge_v_x    (edge_v_x),
    .edge_v_y    (edge_v_y),
    .edge_v_z    (edge_v_z),
    .half_size_x (half_size_x),
    .half_size_y (half_size_y),
    .half_size_z (half_size_z),
    .done        (done),
    .overlaps    (overlaps)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note_request(tri_box_t'{base_x, base_y, base_z, edge_u_x, edge_u_y, edge_u_z,
                                   edge_v_x, edge_v_y, edge_v_z,
                                   half_size_x, half_size_y, half_size_z});
      if (done) sb.check_result(overlaps);
    end
  end

  function automatic coord_t clip_coord(longint x);
    if (x > COORD_MAX) return coord_t'(COORD_MAX);
    if (x < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(x);
  endfunction

  function automatic coord_t rnd_coord(int s);
    return clip_coord(longint'($urandom_range(2 * s)) - s);
  endfunction

  function automatic tri_box_t make_req(int bx, int by, int bz, int ux, int uy, int uz,
                                        int vx, int vy, int vz, int hx, int hy, int hz);
    tri_box_t r;
    r.base_x = coord_t'(bx);   r.base_y = coord_t'(by);   r.base_z = coord_t'(bz);
    r.edge_u_x = coord_t'(ux); r.edge_u_y = coord_t'(uy); r.edge_u_z = coord_t'(uz);
    r.edge_v_x = coord_t'(vx); r.edge_v_y = coord_t'(vy); r.edge_v_z = coord_t'(vz);
    r.half_size_x = half_t'(hx); r.half_size_y = half_t'(hy); r.half_size_z = half_t'(hz);
    return r;
  endfunction

  function automatic tri_box_t scaled_request(int s);
    return make_req(rnd_coord(s), rnd_coord(s), rnd_coord(s),
                    rnd_coord(s), rnd_coord(s), rnd_coord(s),
                    rnd_coord(s), rnd_coord(s), rnd_coord(s),
                    $urandom_range(s), $urandom_range(s), $urandom_range(s));
  endfunction

  function automatic tri_box_t random_request();
    tri_box_t r;
    int kind;
    int s;
    int hb;
    kind = $urandom_range(99);
    case ($urandom_range(3))
      0: s = 4;
      1: s = 64;
      2: s = 1024;
      default: s = COORD_MAX;
    endcase
    r = scaled_request(s);
    if (kind < 15) begin
      // raw bits across the full field range
      r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 60) begin
      // plain scaled geometry
    end else if (kind < 80) begin
      // base vertex close to a box face on some axes
      hb = $urandom_range(1000);
      r = make_req(rnd_coord(hb), rnd_coord(hb), rnd_coord(hb),
                   rnd_coord(40), rnd_coord(40), rnd_coord(40),
                   rnd_coord(40), rnd_coord(40), rnd_coord(40), hb, hb, hb);
      r.half_size_x = half_t'($urandom_range(1000));
      if ($urandom_range(1))
        r.base_x = clip_coord(($urandom_range(1) ? 1 : -1) * longint'(r.half_size_x)
                              + $urandom_range(6) - 3);
      if ($urandom_range(1))
        r.base_y = clip_coord(($urandom_range(1) ? 1 : -1) * longint'(r.half_size_y)
                              + $urandom_range(6) - 3);
      if ($urandom_range(1))
        r.base_z = clip_coord(($urandom_range(1) ? 1 : -1) * longint'(r.half_size_z)
                              + $urandom_range(6) - 3);
    end else if (kind < 90) begin
      // degenerate triangle: zero edge or collinear edges
      case ($urandom_range(2))
        0: begin
          r.edge_u_x = '0; r.edge_u_y = '0; r.edge_u_z = '0;
        end
        1: begin
          hb = $urandom_range(1) ? 2 : -1;
          r.edge_v_x = clip_coord(hb * longint'(r.edge_u_x));
          r.edge_v_y = clip_coord(hb * longint'(r.edge_u_y));
          r.edge_v_z = clip_coord(hb * longint'(r.edge_u_z));
        end
        default: begin
          r.edge_u_x = '0; r.edge_u_y = '0; r.edge_u_z = '0;
          r.edge_v_x = '0; r.edge_v_y = '0; r.edge_v_z = '0;
        end
      endcase
    end else begin
      // flat box or point box
      if ($urandom_range(1)) r.half_size_x = '0;
      if ($urandom_range(1)) r.half_size_y = '0;
      if ($urandom_range(1)) r.half_size_z = '0;
    end
    return r;
  endfunction

  task automatic drive_fields(tri_box_t r);
    base_x <= r.base_x;
    base_y <= r.base_y;
    base_z <= r.base_z;
    edge_u_x <= r.edge_u_x;
    edge_u_y <= r.edge_u_y;
    edge_u_z <= r.edge_u_z;
    edge_v_x <= r.edge_v_x;
    edge_v_y <= r.edge_v_y;
    edge_v_z <= r.edge_v_z;
    half_size_x <= r.half_size_x;
    half_size_y <= r.half_size_y;
    half_size_z <= r.half_size_z;
  endtask

  // returns just after the edge that takes the request
  task automatic send(tri_box_t r);
    start <= 1'b1;
    drive_fields(r);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    bit quiet;
    rst <= 1'b1;
    start <= 1'b0;
    drive_fields(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send(make_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
    send(make_req(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                  COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 0, COORD_MAX));
    send(make_req(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, COORD_MIN,
                  COORD_MAX, COORD_MIN, 0, 0, COORD_MAX, 1));
    // triangle lying on a box face, then one step outside
    send(make_req(10, -3, -3, 0, 6, 0, 0, 0, 6, 10, 10, 10));
    send(make_req(11, -3, -3, 0, 6, 0, 0, 0, 6, 10, 10, 10));
    // triangle in the plane x+y=20: touches a box edge, then clears it
    send(make_req(20, 0, -50, -20, 20, 0, -10, 10, 100, 10, 10, 10));
    send(make_req(21, 0, -50, -20, 20, 0, -10, 10, 100, 10, 10, 10));
    // collinear triangles: one through the box, one beside it
    send(make_req(-20, -20, -20, 40, 40, 40, 20, 20, 20, 3, 3, 3));
    send(make_req(-20, -12, 0, 40, 40, 0, 20, 20, 0, 3, 3, 3));
    // single-point triangles
    send(make_req(1, -2, 3, 0, 0, 0, 0, 0, 0, 5, 5, 5));
    send(make_req(6, 0, 0, 0, 0, 0, 0, 0, 0, 5, 5, 5));
    // point box on and off the triangle plane
    send(make_req(-5, -5, 0, 10, 0, 0, 0, 10, 0, 0, 0, 0));
    send(make_req(-5, -5, 1, 10, 0, 0, 0, 10, 0, 0, 0, 0));
    // normal along z only, plane on the top face
    send(make_req(-5, -5, 3, 20, 0, 0, 0, 20, 0, 5, 5, 3));
    // slanted plane beyond the far corner, then touching it, then just beyond it again
    send(make_req(20, 0, 0, -20, 20, 0, -20, 0, 20, 5, 5, 5));
    send(make_req(15, 0, 0, -15, 15, 0, -15, 0, 15, 5, 5, 5));
    send(make_req(16, 0, 0, -16, 16, 0, -16, 0, 16, 5, 5, 5));

    wait_drained();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = (k >= 300 && k < 500);
      if (k == 650) wait_drained();
      while (!quiet && $urandom_range(99) < 26) begin
        start <= 1'b0;
        @(posedge clk);
      end
      send(random_request());
    end

    wait_drained();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    sb.check_drained();

    $display("Ran %0d triangle/box pairs: extremes, touching, flat box and degenerate cases,",
             sb.requests_seen);
    $display("then random geometry at several scales; %0d results (%0d overlap), %0d mismatches",
             sb.results_checked, sb.overlap_count, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("triangle_box_overlap_test verification clean");
    end else begin
      $display("triangle_box_overlap_test verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout waiting for the overlap pipeline");
    $display("triangle_box_overlap_test verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/tbo_pkg.sv
sv/tbo_face.sv
sv/tbo_edge_axes.sv
sv/tbo_plane.sv
sv/triangle_box_overlap_test.sv
tb/tb.sv
